FILE: hw/rtl/encoder_frame_multiturn_tracker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the encoder frame multi-turn tracker
// Shared clocking and reset gating for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ENCODER_FRAME_MULTITURN_TRACKER_DEFINES_SVH
`define ENCODER_FRAME_MULTITURN_TRACKER_DEFINES_SVH

// Check on clk, gated off while rst_n is low.
`define EFTRK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on clk that also holds during reset.
`define EFTRK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/eftrk_pkg.sv
// ----------------------------------------------------------------------------
// eftrk_pkg
// Types and constants shared by the encoder frame tracker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eftrk_pkg;

  localparam int ANGLE_W = 21;
  localparam int POS_W   = 32;
  localparam int ERR_W   = 16;
  localparam int DIFF_W  = ANGLE_W + 1;

  // item command codes
  localparam logic CMD_FRAME   = 1'b0;
  localparam logic CMD_SET_POS = 1'b1;

  // frame formats
  localparam logic MODE_PARITY18 = 1'b0;
  localparam logic MODE_CRC21    = 1'b1;

  // half a turn in counts, per format
  localparam logic signed [DIFF_W-1:0] HALF_TURN_MODE0 = 22'sd131072;
  localparam logic signed [DIFF_W-1:0] HALF_TURN_MODE1 = 22'sd1048576;

  localparam logic [ERR_W-1:0] ERR_MAX = 16'hFFFF;

  // CRC-8 (x^8+x^2+x+1, init 0) is linear in the 24 message bits:
  // entry j is x^(j+8) mod P, bit 23 being the first bit sent.
  localparam logic [7:0] CRC_COL [24] = '{
    8'h07, 8'h0E, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hC7, 8'h89,
    8'h15, 8'h2A, 8'h54, 8'hA8, 8'h57, 8'hAE, 8'h5B, 8'hB6,
    8'h6B, 8'hD6, 8'hAB, 8'h51, 8'hA2, 8'h43, 8'h86, 8'h0B
  };

  typedef struct packed {
    logic                    cmd;
    logic                    mode;
    logic                    ok;
    logic [ANGLE_W-1:0]      angle;
    logic                    no_magnet;
    logic                    over_speed;
    logic signed [POS_W-1:0] new_position;
  } item_t;

  function automatic logic [7:0] crc8_24(input logic [23:0] msg);
    logic [7:0] crc;
    crc = 8'h00;
    for (int j = 0; j < 24; j++) begin
      if (msg[j]) begin
        crc = crc ^ CRC_COL[j];
      end
    end
    return crc;
  endfunction

endpackage

FILE: hw/rtl/eftrk_front.sv
// ----------------------------------------------------------------------------
// eftrk_front
// Holds the frame format and decodes each accepted item into a queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eftrk_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  input  logic                           in_cmd,
  input  logic [7:0]                     in_frame_byte0,
  input  logic [7:0]                     in_frame_byte1,
  input  logic [7:0]                     in_frame_byte2,
  input  logic [7:0]                     in_frame_byte3,
  input  logic signed [eftrk_pkg::POS_W-1:0] in_new_position,
  output eftrk_pkg::item_t               item
);

  logic       mode_r;
  logic       par_ok;
  logic       crc_ok;
  logic [7:0] crc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= eftrk_pkg::MODE_PARITY18;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  always_comb begin
    // even parity over the 16-bit word and over byte2[7:2]
    par_ok = !(^{in_frame_byte0, in_frame_byte1}) && !(^in_frame_byte2[7:2]);
    crc    = eftrk_pkg::crc8_24({in_frame_byte0, in_frame_byte1, in_frame_byte2});
    crc_ok = (crc == in_frame_byte3);

    item.cmd          = in_cmd;
    item.mode         = mode_r;
    item.new_position = in_new_position;
    if (mode_r == eftrk_pkg::MODE_CRC21) begin
      item.angle      = {in_frame_byte0, in_frame_byte1, in_frame_byte2[7:3]};
      item.no_magnet  = in_frame_byte2[1];
      item.over_speed = in_frame_byte2[0];
      item.ok         = crc_ok;
    end else begin
      item.angle      = {3'b000, in_frame_byte0, in_frame_byte1[7:2], in_frame_byte2[7:4]};
      item.no_magnet  = in_frame_byte1[1];
      item.over_speed = in_frame_byte2[3];
      item.ok         = par_ok;
    end
    // a set-position item never reports a good check
    if (in_cmd == eftrk_pkg::CMD_SET_POS) begin
      item.ok = 1'b0;
    end
  end

endmodule

FILE: hw/rtl/eftrk_queue.sv
// ----------------------------------------------------------------------------
// eftrk_queue
// Small register queue of decoded items between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "encoder_frame_multiturn_tracker_defines.svh"

module eftrk_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  eftrk_pkg::item_t wr_item,
  output logic             q_full,
  input  logic             rd_en,
  output eftrk_pkg::item_t rd_item,
  output logic             q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  eftrk_pkg::item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (cnt_r == DEPTH_CNT);
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  `EFTRK_ASSERT(a_q_no_overfill, cnt_r <= DEPTH_CNT, "queue count above depth")
  `EFTRK_ASSERT(a_q_count_up, do_wr && !do_rd |=> cnt_r == $past(cnt_r) + 1'b1, "queue count did not rise on a lone write")

endmodule

FILE: hw/rtl/eftrk_back.sv
// ----------------------------------------------------------------------------
// eftrk_back
// Applies decoded items to the turn/position state and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "encoder_frame_multiturn_tracker_defines.svh"

module eftrk_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  eftrk_pkg::item_t                       q_item,
  input  logic                                   q_empty,
  output logic                                   q_pop,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [eftrk_pkg::POS_W-1:0]     out_position,
  output logic [eftrk_pkg::ANGLE_W-1:0]          out_angle,
  output logic                                   out_frame_ok,
  output logic                                   out_no_magnet,
  output logic                                   out_over_speed,
  output logic [eftrk_pkg::ERR_W-1:0]            out_error_count
);

  localparam int PW = eftrk_pkg::POS_W;
  localparam int AW = eftrk_pkg::ANGLE_W;
  localparam int EW = eftrk_pkg::ERR_W;
  localparam int DW = eftrk_pkg::DIFF_W;

  // tracking state
  logic [PW-1:0] turn_r,   turn_nxt;
  logic [AW-1:0] last_r,   last_nxt;
  logic [AW-1:0] cur_r,    cur_nxt;
  logic [PW-1:0] abs_r,    abs_nxt;
  logic [PW-1:0] off_r,    off_nxt;
  logic [EW-1:0] err_r,    err_nxt;
  logic          nomag_r,  nomag_nxt;
  logic          ovs_r,    ovs_nxt;

  // result register
  logic          out_valid_r;
  logic [PW-1:0] out_abs_r;
  logic [PW-1:0] out_off_r;
  logic [AW-1:0] out_angle_r;
  logic          out_ok_r;
  logic          out_nomag_r;
  logic          out_ovs_r;
  logic [EW-1:0] out_err_r;

  logic                 take;
  logic                 good;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] half;
  logic [PW-1:0]        turn_sh;

  assign take  = !q_empty && (!out_valid_r || pop);
  assign q_pop = take;
  assign good  = (q_item.cmd == eftrk_pkg::CMD_FRAME) && q_item.ok;

  always_comb begin
    turn_nxt  = turn_r;
    last_nxt  = last_r;
    cur_nxt   = cur_r;
    abs_nxt   = abs_r;
    off_nxt   = off_r;
    err_nxt   = err_r;
    nomag_nxt = nomag_r;
    ovs_nxt   = ovs_r;

    diff = $signed({1'b0, q_item.angle}) - $signed({1'b0, last_r});
    half = (q_item.mode == eftrk_pkg::MODE_CRC21) ? eftrk_pkg::HALF_TURN_MODE1
                                                  : eftrk_pkg::HALF_TURN_MODE0;
    turn_sh = '0;

    if (q_item.cmd == eftrk_pkg::CMD_SET_POS) begin
      off_nxt = abs_r - PW'(q_item.new_position);
    end else begin
      cur_nxt   = q_item.angle;
      nomag_nxt = q_item.no_magnet;
      ovs_nxt   = q_item.over_speed;
      if (good) begin
        // a jump of more than half a turn is a wrap through zero
        if (diff > half) begin
          turn_nxt = turn_r - 1'b1;
        end else if (diff < -half) begin
          turn_nxt = turn_r + 1'b1;
        end
        turn_sh = (q_item.mode == eftrk_pkg::MODE_CRC21) ? {turn_nxt[PW-22:0], 21'd0}
                                                         : {turn_nxt[PW-19:0], 18'd0};
        last_nxt = q_item.angle;
        abs_nxt  = turn_sh + PW'(q_item.angle);
      end else if (err_r != eftrk_pkg::ERR_MAX) begin
        err_nxt = err_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r      <= '0;
      last_r      <= '0;
      cur_r       <= '0;
      abs_r       <= '0;
      off_r       <= '0;
      err_r       <= '0;
      nomag_r     <= 1'b0;
      ovs_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (cfg_we) begin
      // format change restarts tracking; the offset survives
      turn_r  <= '0;
      last_r  <= '0;
      cur_r   <= '0;
      abs_r   <= '0;
      err_r   <= '0;
      nomag_r <= 1'b0;
      ovs_r   <= 1'b0;
    end else begin
      if (take) begin
        turn_r  <= turn_nxt;
        last_r  <= last_nxt;
        cur_r   <= cur_nxt;
        abs_r   <= abs_nxt;
        off_r   <= off_nxt;
        err_r   <= err_nxt;
        nomag_r <= nomag_nxt;
        ovs_r   <= ovs_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !cfg_we) begin
      out_abs_r   <= abs_nxt;
      out_off_r   <= off_nxt;
      out_angle_r <= cur_nxt;
      out_ok_r    <= good;
      out_nomag_r <= nomag_nxt;
      out_ovs_r   <= ovs_nxt;
      out_err_r   <= err_nxt;
    end
  end

  assign empty           = !out_valid_r;
  assign out_position    = $signed(out_abs_r - out_off_r);
  assign out_angle       = out_angle_r;
  assign out_frame_ok    = out_ok_r;
  assign out_no_magnet   = out_nomag_r;
  assign out_over_speed  = out_ovs_r;
  assign out_error_count = out_err_r;

  `EFTRK_ASSERT(a_bad_frame_keeps_turns, take && !good && !cfg_we |=> $stable(turn_r) && $stable(abs_r), "bad frame or set-position changed the turn state")
  `EFTRK_ASSERT(a_err_monotonic, !cfg_we |=> err_r >= $past(err_r), "error count went down without a format write")
  `EFTRK_ASSERT(a_result_held, out_valid_r && !pop && !cfg_we |=> out_valid_r && $stable(out_abs_r), "waiting result dropped or changed")

endmodule

FILE: hw/rtl/encoder_frame_multiturn_tracker.sv
// ----------------------------------------------------------------------------
// encoder_frame_multiturn_tracker
// Decodes angle-sensor frames and tracks a multi-turn position with offset.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | push / full          | in_cmd, in_frame_byte0..3, in_new_position
//  result   | empty / pop          | out_position, out_angle, out_frame_ok,
//           |                      | out_no_magnet, out_over_speed,
//           |                      | out_error_count
//  config   | cfg_we               | cfg_wdata (sensor mode)
//
//  One item per cycle sustained while the result side keeps popping; an
//  item is decoded into the queue at its transfer edge, then taken by the
//  tracking stage into the result register once that register is free or popped.
//  The tracking stage updates turns and position for each item it takes.
//  Synchronous active-low reset; no clearing pass.
//  A stalled result side fills the queue (QUEUE_DEPTH entries) plus the
//  result register before full rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_frame_multiturn_tracker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_wdata,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_cmd,
  input  logic [7:0]                         in_frame_byte0,
  input  logic [7:0]                         in_frame_byte1,
  input  logic [7:0]                         in_frame_byte2,
  input  logic [7:0]                         in_frame_byte3,
  input  logic signed [eftrk_pkg::POS_W-1:0] in_new_position,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [eftrk_pkg::POS_W-1:0] out_position,
  output logic [eftrk_pkg::ANGLE_W-1:0]      out_angle,
  output logic                               out_frame_ok,
  output logic                               out_no_magnet,
  output logic                               out_over_speed,
  output logic [eftrk_pkg::ERR_W-1:0]        out_error_count
);

  eftrk_pkg::item_t dec_item;
  eftrk_pkg::item_t q_item;
  logic             q_empty;
  logic             q_pop;

  eftrk_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_cmd),
    .in_frame_byte0  (in_frame_byte0),
    .in_frame_byte1  (in_frame_byte1),
    .in_frame_byte2  (in_frame_byte2),
    .in_frame_byte3  (in_frame_byte3),
    .in_new_position (in_new_position),
    .item            (dec_item)
  );

  eftrk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_item (dec_item),
    .q_full  (full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .q_empty (q_empty)
  );

  eftrk_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .q_item          (q_item),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_position    (out_position),
    .out_angle       (out_angle),
    .out_frame_ok    (out_frame_ok),
    .out_no_magnet   (out_no_magnet),
    .out_over_speed  (out_over_speed),
    .out_error_count (out_error_count)
  );

endmodule

FILE: test/encoder_frame_multiturn_tracker_checker.sv
// ----------------------------------------------------------------------------
// Encoder frame tracker checker
// Watches the config port and both queue channels, keeps its own copy of the
// tracking state, predicts one result per accepted item and compares every
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_frame_multiturn_tracker_checker
  import eftrk_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  input  logic                    push,
  input  logic                    full,
  input  logic                    in_cmd,
  input  logic [7:0]              in_frame_byte0,
  input  logic [7:0]              in_frame_byte1,
  input  logic [7:0]              in_frame_byte2,
  input  logic [7:0]              in_frame_byte3,
  input  logic signed [POS_W-1:0] in_new_position,
  input  logic                    empty,
  input  logic                    pop,
  input  logic signed [POS_W-1:0] out_position,
  input  logic [ANGLE_W-1:0]      out_angle,
  input  logic                    out_frame_ok,
  input  logic                    out_no_magnet,
  input  logic                    out_over_speed,
  input  logic [ERR_W-1:0]        out_error_count,
  output int unsigned             outstanding,
  output int unsigned             fail_count
);

  localparam int unsigned COUNTS_18 = 262144;
  localparam int unsigned COUNTS_21 = 2097152;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [ANGLE_W-1:0] angle;
    logic               frame_ok;
    logic               no_magnet;
    logic               over_speed;
    logic [ERR_W-1:0]   error_count;
  } tracker_result_t;

  logic               mode;
  logic [31:0]        turns;
  logic [ANGLE_W-1:0] last_ang;
  logic [ANGLE_W-1:0] cur_ang;
  logic [31:0]        abs_pos;
  logic [31:0]        pos_offset;
  logic [ERR_W-1:0]   err_cnt;
  logic               nm_flag;
  logic               os_flag;

  tracker_result_t pending_results[$];

  function automatic void clear_tracking();
    turns    = '0;
    last_ang = '0;
    cur_ang  = '0;
    abs_pos  = '0;
    err_cnt  = '0;
    nm_flag  = 1'b0;
    os_flag  = 1'b0;
  endfunction

  // serial CRC-8, x^8+x^2+x+1, MSB of byte0 first
  function automatic logic [7:0] frame_crc(input logic [23:0] msg);
    logic [7:0] crc;
    logic       fb;
    crc = 8'h00;
    for (int i = 23; i >= 0; i--) begin
      fb  = msg[i] ^ crc[7];
      crc = {crc[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
    end
    return crc;
  endfunction

  function automatic tracker_result_t track_item(input logic cmd, input logic [7:0] b0,
                                                 input logic [7:0] b1, input logic [7:0] b2,
                                                 input logic [7:0] b3,
                                                 input logic [31:0] new_pos);
    tracker_result_t r;
    logic            ok;
    int unsigned     cpr;
    int              lim;
    int              diff;
    ok = 1'b0;
    if (cmd == CMD_SET_POS) begin
      pos_offset = abs_pos - new_pos;
    end else begin
      if (mode == MODE_PARITY18) begin
        cpr     = COUNTS_18;
        cur_ang = {3'b000, b0, b1[7:2], b2[7:4]};
        nm_flag = b1[1];
        os_flag = b2[3];
        ok      = ~(^{b0, b1}) & ~(^b2[7:2]);
      end else begin
        cpr     = COUNTS_21;
        cur_ang = {b0, b1, b2[7:3]};
        nm_flag = b2[1];
        os_flag = b2[0];
        ok      = (frame_crc({b0, b1, b2}) == b3);
      end
      if (ok) begin
        // jump beyond half a turn in either direction is a wrap
        lim  = int'(cpr / 2);
        diff = int'(cur_ang) - int'(last_ang);
        if (diff > lim) begin
          turns = turns - 1;
        end else if (-diff > lim) begin
          turns = turns + 1;
        end
        last_ang = cur_ang;
        abs_pos  = turns * cpr + cur_ang;
      end else if (err_cnt != ERR_MAX) begin
        err_cnt = err_cnt + 1'b1;
      end
    end
    r.position    = abs_pos - pos_offset;
    r.angle       = cur_ang;
    r.frame_ok    = ok;
    r.no_magnet   = nm_flag;
    r.over_speed  = os_flag;
    r.error_count = err_cnt;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    tracker_result_t want;
    if (!rst_n) begin
      mode       = MODE_PARITY18;
      pos_offset = '0;
      clear_tracking();
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        mode = cfg_wdata;
        clear_tracking();
      end
      if (push && !full) begin
        pending_results.push_back(track_item(in_cmd, in_frame_byte0, in_frame_byte1,
                                             in_frame_byte2, in_frame_byte3,
                                             in_new_position));
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: out_position 0x%0h", out_position);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_position", want.position, out_position);
          check_field("out_angle", want.angle, out_angle);
          check_field("out_frame_ok", want.frame_ok, out_frame_ok);
          check_field("out_no_magnet", want.no_magnet, out_no_magnet);
          check_field("out_over_speed", want.over_speed, out_over_speed);
          check_field("out_error_count", want.error_count, out_error_count);
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: test/encoder_frame_multiturn_tracker_test.sv
// ----------------------------------------------------------------------------
// Encoder frame multi-turn tracker testbench
// Directed frames in both sensor modes (wraps, exact half turns, flags, bad
// checks, position sets at the 32-bit extremes), then random walks of
// well-formed frames mixed with broken frames, noise and position sets under
// several idle/stall profiles, then a short unstalled tail in each format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_frame_multiturn_tracker_test;
  import eftrk_pkg::*;

  logic                    clk             = 1'b0;
  logic                    rst_n           = 1'b0;
  logic                    cfg_we          = 1'b0;
  logic                    cfg_wdata       = 1'b0;
  logic                    push            = 1'b0;
  logic                    full;
  logic                    in_cmd          = CMD_FRAME;
  logic [7:0]              in_frame_byte0  = 8'h00;
  logic [7:0]              in_frame_byte1  = 8'h00;
  logic [7:0]              in_frame_byte2  = 8'h00;
  logic [7:0]              in_frame_byte3  = 8'h00;
  logic signed [POS_W-1:0] in_new_position = '0;
  logic                    empty;
  logic                    pop             = 1'b0;
  logic signed [POS_W-1:0] out_position;
  logic [ANGLE_W-1:0]      out_angle;
  logic                    out_frame_ok;
  logic                    out_no_magnet;
  logic                    out_over_speed;
  logic [ERR_W-1:0]        out_error_count;
  int unsigned             outstanding;
  int unsigned             fail_count;

  int   send_idle   = 0;
  int   recv_stall  = 0;
  int   trk_last    = 0;
  logic sensor_mode = MODE_PARITY18;

  int n_good, n_bad, n_noise, n_setpos, n_mode_writes;

  int   send_gap_pct [4] = '{0, 76, 0, 22};
  int   recv_gap_pct [4] = '{0, 0, 76, 22};
  logic phase_mode   [8] = '{MODE_PARITY18, MODE_CRC21, MODE_CRC21, MODE_PARITY18,
                             MODE_PARITY18, MODE_CRC21, MODE_PARITY18, MODE_CRC21};

  always #6 clk = ~clk;

  encoder_frame_multiturn_tracker u_dut (.*);

  encoder_frame_multiturn_tracker_checker u_check (.*);

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall);
  end

  initial begin
    #24_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(input logic c, input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3,
                           input logic [31:0] new_pos);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    in_cmd          <= c;
    in_frame_byte0  <= b0;
    in_frame_byte1  <= b1;
    in_frame_byte2  <= b2;
    in_frame_byte3  <= b3;
    in_new_position <= new_pos;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    repeat (4) @(posedge clk);
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we      <= 1'b0;
    sensor_mode = m;
    trk_last    = 0;
    n_mode_writes++;
  endtask

  // packs {byte0, byte1, byte2, byte3}; a bad frame gets one broken check
  function automatic logic [31:0] build_frame(input logic [20:0] ang, input logic nm,
                                              input logic os, input logic good);
    logic [7:0]  b0, b1, b2, b3;
    int unsigned k;
    if (sensor_mode == MODE_PARITY18) begin
      b0    = ang[17:10];
      b1    = {ang[9:4], nm, 1'b0};
      b1[0] = ^{b0, b1[7:1]};
      b2    = {ang[3:0], os, 1'b0, 2'($urandom_range(3))};
      b2[2] = ^b2[7:3];
      b3    = 8'($urandom_range(255));
      if (!good) begin
        k = $urandom_range(21);
        if (k < 8) begin
          b0[k] = ~b0[k];
        end else if (k < 16) begin
          b1[k-8] = ~b1[k-8];
        end else begin
          b2[k-14] = ~b2[k-14];
        end
      end
    end else begin
      b0 = ang[20:13];
      b1 = ang[12:5];
      b2 = {ang[4:0], 1'($urandom_range(1)), nm, os};
      b3 = crc8_24({b0, b1, b2});
      if (!good) begin
        b3 = b3 ^ 8'($urandom_range(255, 1));
      end
    end
    return {b0, b1, b2, b3};
  endfunction

  task automatic send_frame(input int ang, input logic nm, input logic os, input logic good);
    logic [31:0] fb;
    fb = build_frame(ang[20:0], nm, os, good);
    send_item(CMD_FRAME, fb[31:24], fb[23:16], fb[15:8], fb[7:0], $urandom);
    if (good) begin
      trk_last = ang;
      n_good++;
    end else begin
      n_bad++;
    end
  endtask

  task automatic send_raw(input logic [31:0] bytes);
    send_item(CMD_FRAME, bytes[31:24], bytes[23:16], bytes[15:8], bytes[7:0], $urandom);
    n_noise++;
  endtask

  task automatic send_setpos(input logic [31:0] v);
    send_item(CMD_SET_POS, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), v);
    n_setpos++;
  endtask

  // random walk around the last good angle, biased toward the half-turn edge
  function automatic int next_angle();
    int          cpr, half, step;
    int unsigned pick;
    cpr  = (sensor_mode == MODE_CRC21) ? 2097152 : 262144;
    half = cpr / 2;
    pick = $urandom_range(99);
    if (pick < 45) begin
      step = int'($urandom_range(cpr / 32)) - cpr / 64;
    end else if (pick < 65) begin
      step = half + int'($urandom_range(4)) - 2;
      if ($urandom_range(1)) step = -step;
    end else if (pick < 80) begin
      step = int'($urandom_range(6)) - 3;
    end else begin
      step = int'($urandom_range(cpr - 1)) - trk_last;
    end
    return (trk_last + step) & (cpr - 1);
  endfunction

  task automatic random_item();
    int unsigned pick;
    logic        nm, os;
    pick = $urandom_range(99);
    nm   = ($urandom_range(7) == 0);
    os   = ($urandom_range(7) == 0);
    if (pick < 72) begin
      send_frame(next_angle(), nm, os, 1'b1);
    end else if (pick < 84) begin
      send_frame(next_angle(), nm, os, 1'b0);
    end else if (pick < 92) begin
      case ($urandom_range(7))
        0:       send_setpos(32'h7FFF_FFFF);
        1:       send_setpos(32'h8000_0000);
        2:       send_setpos(32'h0000_0000);
        3:       send_setpos(32'hFFFF_FFFF);
        default: send_setpos($urandom);
      endcase
    end else begin
      send_raw($urandom);
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 18-bit parity frames
    write_mode(MODE_PARITY18);
    send_frame(0, 1'b0, 1'b0, 1'b1);
    send_frame(262143, 1'b0, 1'b0, 1'b1);   // backward wrap
    send_frame(0, 1'b0, 1'b0, 1'b1);        // forward wrap
    send_frame(131072, 1'b0, 1'b0, 1'b1);   // exactly half a turn: no wrap
    send_frame(0, 1'b0, 1'b0, 1'b1);
    send_frame(32'h2AAAA, 1'b1, 1'b1, 1'b1);
    send_frame(5, 1'b1, 1'b0, 1'b0);
    send_raw(32'hFFFF_FFFF);
    send_setpos(32'h7FFF_FFFF);
    send_setpos(32'h8000_0000);
    send_frame(1, 1'b0, 1'b1, 1'b1);
    send_raw(32'h0000_0000);

    // 21-bit CRC frames, offset carries over the mode change
    write_mode(MODE_CRC21);
    send_frame(2097151, 1'b1, 1'b1, 1'b1);
    send_frame(0, 1'b0, 1'b0, 1'b1);
    send_frame(1048576, 1'b0, 1'b0, 1'b1);
    send_frame(0, 1'b0, 1'b0, 1'b1);
    send_frame(1048577, 1'b0, 1'b0, 1'b1);
    send_frame(77, 1'b1, 1'b1, 1'b0);
    send_setpos(32'h0000_0000);
    send_raw(32'hFFFF_FFFF);
    send_frame(12345, 1'b0, 1'b0, 1'b1);

    for (int p = 0; p < 8; p++) begin
      write_mode(phase_mode[p]);
      send_idle  = send_gap_pct[p % 4];
      recv_stall <= recv_gap_pct[p % 4];
      for (int i = 0; i < 150; i++) begin
        if (i == 75) drain();
        random_item();
      end
    end

    // short unstalled tail in each format
    write_mode(MODE_CRC21);
    send_idle  = 0;
    recv_stall <= 0;
    for (int i = 0; i < 20; i++) begin
      random_item();
    end
    write_mode(MODE_PARITY18);
    for (int i = 0; i < 20; i++) begin
      random_item();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d good frames, %0d broken frames, %0d raw frames, %0d position sets",
             n_good, n_bad, n_noise, n_setpos);
    $display("over %0d mode writes, with sender gaps and result stalls",
             n_mode_writes);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
